// ===== rtl/adcbd_pkg.sv =====
// Shared types and constants for the dual-CPU bus decoder.
// No dependencies. Used by arcade_dual_cpu_bus_decoder and adcbd_checker.
package adcbd_pkg;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_TICK      = 3'd2,
        OP_IRQ_ACK   = 3'd3,
        OP_FRAME     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CFG_DIP_ONE      = 3'd0,
        CFG_DIP_TWO_BASE = 3'd1,
        CFG_DEMO_ON      = 3'd2,
        CFG_DEMO_OFF     = 3'd3,
        CFG_PRESCALE     = 3'd4
    } cfg_idx_t;

    // which RAM an address lands in
    typedef enum logic [2:0] {
        RAM_NONE,
        RAM_COLOUR,
        RAM_VIDEO,
        RAM_WORK,
        RAM_SPR_A,
        RAM_SPR_B,
        RAM_SOUND
    } ram_sel_t;

    // bit latch output selects
    localparam logic [2:0] LATCH_NMI   = 3'd0;
    localparam logic [2:0] LATCH_IRQ   = 3'd2;
    localparam logic [2:0] LATCH_VIDEO = 3'd4;

    localparam logic [3:0] PSG_PORT_A = 4'd14;
    localparam logic [3:0] PSG_PORT_B = 4'd15;

    localparam logic [15:0] MAIN_ROM_TOP  = 16'h6000;
    localparam logic [15:0] SND_ROM_TOP   = 16'h1000;
    localparam logic [15:0] SND_GAP_TOP   = 16'h3000;
    localparam logic [15:0] ADDR_SCANLINE = 16'hC000;
    localparam logic [15:0] ADDR_DIP_TWO  = 16'hC200;
    localparam logic [15:0] ADDR_IN_ZERO  = 16'hC300;
    localparam logic [15:0] ADDR_IN_ONE   = 16'hC320;
    localparam logic [15:0] ADDR_IN_TWO   = 16'hC340;
    localparam logic [15:0] ADDR_DIP_ONE  = 16'hC360;
    localparam logic [11:0] LATCH_PAGE    = 12'hC30;

    localparam logic [7:0] CFG_DIP_RESET      = 8'hFF;
    localparam logic [7:0] CFG_PRESCALE_RESET = 8'd45;
    localparam logic [3:0] DECADE_LAST        = 4'd9;

    typedef struct packed {
        logic [2:0]  op;
        logic        cpu_select;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  scanline_count;
        logic [6:0]  buttons;
        logic        demo_sound_off;
    } in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_select;
        logic [14:0] rom_address;
        logic        audio_write;
        logic [4:0]  audio_reg_index;
        logic [7:0]  audio_reg_value;
        logic        sound_irq_pending;
        logic        nmi_enabled;
        logic        video_enabled;
        logic        scanline_read_seen;
        logic        game_running;
    } out_t;

    function automatic logic [7:0] decade_lookup(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h10;
            4'd2:    v = 8'h20;
            4'd3:    v = 8'h30;
            4'd4:    v = 8'h40;
            4'd5:    v = 8'h90;
            4'd6:    v = 8'ha0;
            4'd7:    v = 8'hb0;
            4'd8:    v = 8'ha0;
            4'd9:    v = 8'hd0;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/arcade_dual_cpu_bus_decoder.sv =====
// Bus decoder, RAMs and sound register file for a main and a sound CPU.
// Each accepted word passes through stage one (RAM read) and then the output register
// before its result handshake. Throughput: one word per cycle while m_ready stays high.
// Reset (aresetn, synchronous, active low): clears handshake, latches, flags, timer,
// sound chip registers and address latches; config registers take reset values.
// RAM contents are not cleared and have no clearing pass.
module arcade_dual_cpu_bus_decoder (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  adcbd_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output adcbd_pkg::out_t  m_data
);

    // config
    logic [7:0] dip_one_reg, dip_two_reg, demo_on_reg, demo_off_reg, prescale_cfg_reg;

    // control state
    logic [3:0] psg_addr0_reg, psg_addr0_next;
    logic [3:0] psg_addr1_reg, psg_addr1_next;
    logic [7:0] sound_latch_reg, sound_latch_next;
    logic       nmi_reg, nmi_next;
    logic       video_reg, video_next;
    logic       irq_prev_reg, irq_prev_next;
    logic       irq_wait_reg, irq_wait_next;
    logic       started_reg, started_next;
    logic       seen_reg, seen_next;
    logic [7:0] prescale_reg, prescale_next;
    logic [3:0] decade_reg, decade_next;
    logic [7:0] pre_inc;

    logic [7:0] psg_reg [32];
    logic       psg_we;
    logic [4:0] psg_widx;
    logic [4:0] psg_ridx;

    // pipeline
    logic                 s_accept, adv;
    logic                 st1_valid_reg;
    adcbd_pkg::out_t      st1_res_reg, res_next;
    adcbd_pkg::out_t      st1_out;
    adcbd_pkg::ram_sel_t  st1_sel_reg, rd_sel;
    adcbd_pkg::ram_sel_t  ram_hit;
    logic                 m_valid_reg;
    adcbd_pkg::out_t      m_data_reg;

    // memories
    logic [7:0] colour_mem [1024];
    logic [7:0] video_mem  [1024];
    logic [7:0] work_mem   [2048];
    logic [7:0] spr_a_mem  [256];
    logic [7:0] spr_b_mem  [256];
    logic [7:0] sound_mem  [1024];
    logic [7:0] colour_q_reg, video_q_reg, work_q_reg, spr_a_q_reg, spr_b_q_reg, sound_q_reg;
    logic       ram_wr;
    logic [7:0] ram_q;

    logic [15:0] a;
    logic [6:0]  keys;

    assign a    = s_data.address;
    assign keys = s_data.buttons;

    assign adv      = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // RAM region of the incoming address
    always_comb begin
        ram_hit = adcbd_pkg::RAM_NONE;
        if (s_data.cpu_select) begin
            if (a[15:12] == 4'h3) ram_hit = adcbd_pkg::RAM_SOUND;
        end else begin
            if (a[15:10] == 6'b101000)      ram_hit = adcbd_pkg::RAM_COLOUR;
            else if (a[15:10] == 6'b101001) ram_hit = adcbd_pkg::RAM_VIDEO;
            else if (a[15:11] == 5'b10101)  ram_hit = adcbd_pkg::RAM_WORK;
            else if (a[15:10] == 6'b101100) ram_hit = adcbd_pkg::RAM_SPR_A;
            else if (a[15:10] == 6'b101101) ram_hit = adcbd_pkg::RAM_SPR_B;
        end
    end

    assign ram_wr = s_accept && (s_data.op == adcbd_pkg::OP_WRITE);

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_COLOUR) colour_mem[a[9:0]] <= s_data.write_data;
        if (s_accept) colour_q_reg <= colour_mem[a[9:0]];
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_VIDEO) video_mem[a[9:0]] <= s_data.write_data;
        if (s_accept) video_q_reg <= video_mem[a[9:0]];
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_WORK) work_mem[a[10:0]] <= s_data.write_data;
        if (s_accept) work_q_reg <= work_mem[a[10:0]];
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_SPR_A) spr_a_mem[a[7:0]] <= s_data.write_data;
        if (s_accept) spr_a_q_reg <= spr_a_mem[a[7:0]];
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_SPR_B) spr_b_mem[a[7:0]] <= s_data.write_data;
        if (s_accept) spr_b_q_reg <= spr_b_mem[a[7:0]];
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && ram_hit == adcbd_pkg::RAM_SOUND) sound_mem[a[9:0]] <= s_data.write_data;
        if (s_accept) sound_q_reg <= sound_mem[a[9:0]];
    end

    // read index into the sound chip file: chip two sits on page 6
    assign psg_ridx = (a[15:12] == 4'h6) ? {1'b1, psg_addr1_reg} : {1'b0, psg_addr0_reg};
    assign pre_inc  = prescale_reg + 8'd1;

    always_comb begin
        res_next         = '0;
        rd_sel           = adcbd_pkg::RAM_NONE;
        psg_we           = 1'b0;
        psg_widx         = '0;
        psg_addr0_next   = psg_addr0_reg;
        psg_addr1_next   = psg_addr1_reg;
        sound_latch_next = sound_latch_reg;
        nmi_next         = nmi_reg;
        video_next       = video_reg;
        irq_prev_next    = irq_prev_reg;
        irq_wait_next    = irq_wait_reg;
        started_next     = started_reg;
        seen_next        = seen_reg;
        prescale_next    = prescale_reg;
        decade_next      = decade_reg;

        case (s_data.op)
            adcbd_pkg::OP_READ: begin
                rd_sel = ram_hit;
                if (s_data.cpu_select) begin
                    if (a < adcbd_pkg::SND_ROM_TOP) begin
                        res_next.rom_select  = 1'b1;
                        res_next.rom_address = a[14:0];
                    end else if (a < adcbd_pkg::SND_GAP_TOP) begin
                        res_next.read_data = 8'hFF;
                    end else if (a[15:12] == 4'h3) begin
                        res_next.read_data = 8'h00;
                    end else if (a[15:12] == 4'h4) begin
                        if (psg_addr0_reg == adcbd_pkg::PSG_PORT_A)
                            res_next.read_data = sound_latch_reg;
                        else if (psg_addr0_reg == adcbd_pkg::PSG_PORT_B)
                            res_next.read_data = adcbd_pkg::decade_lookup(decade_reg);
                        else
                            res_next.read_data = psg_reg[psg_ridx];
                    end else if (a[15:12] == 4'h6) begin
                        res_next.read_data = psg_reg[psg_ridx];
                    end else begin
                        res_next.read_data = 8'hFF;
                    end
                end else begin
                    if (a < adcbd_pkg::MAIN_ROM_TOP) begin
                        res_next.rom_select  = 1'b1;
                        res_next.rom_address = a[14:0];
                    end else if (ram_hit != adcbd_pkg::RAM_NONE) begin
                        res_next.read_data = 8'h00;
                    end else if (a == adcbd_pkg::ADDR_SCANLINE) begin
                        seen_next          = 1'b1;
                        res_next.read_data = s_data.scanline_count;
                    end else if (a == adcbd_pkg::ADDR_DIP_TWO) begin
                        res_next.read_data = dip_two_reg |
                            (s_data.demo_sound_off ? demo_off_reg : demo_on_reg);
                    end else if (a == adcbd_pkg::ADDR_IN_ZERO) begin
                        res_next.read_data = {4'hF, ~keys[1], 2'b11, ~keys[0]};
                    end else if (a == adcbd_pkg::ADDR_IN_ONE) begin
                        res_next.read_data = {3'b111, ~keys[6], ~keys[5], ~keys[4],
                                              ~keys[3], ~keys[2]};
                    end else if (a == adcbd_pkg::ADDR_IN_TWO) begin
                        res_next.read_data = 8'hFF;
                    end else if (a == adcbd_pkg::ADDR_DIP_ONE) begin
                        res_next.read_data = dip_one_reg;
                    end
                end
            end
            adcbd_pkg::OP_WRITE: begin
                if (s_data.cpu_select) begin
                    case (a[15:12])
                        4'h4: begin
                            psg_we   = 1'b1;
                            psg_widx = {1'b0, psg_addr0_reg};
                        end
                        4'h5: psg_addr0_next = s_data.write_data[3:0];
                        4'h6: begin
                            psg_we   = 1'b1;
                            psg_widx = {1'b1, psg_addr1_reg};
                        end
                        4'h7: psg_addr1_next = s_data.write_data[3:0];
                        default: ;
                    endcase
                    // ports A and B of each chip do not reach the audio engine
                    if (psg_we && psg_widx[3:0] < adcbd_pkg::PSG_PORT_A) begin
                        res_next.audio_write     = 1'b1;
                        res_next.audio_reg_index = psg_widx;
                        res_next.audio_reg_value = s_data.write_data;
                    end
                end else begin
                    if (ram_hit == adcbd_pkg::RAM_VIDEO) begin
                        started_next = 1'b1;
                    end else if (ram_hit == adcbd_pkg::RAM_NONE) begin
                        if (a == adcbd_pkg::ADDR_SCANLINE) begin
                            sound_latch_next = s_data.write_data;
                        end else if (a[15:4] == adcbd_pkg::LATCH_PAGE) begin
                            case (a[3:1])
                                adcbd_pkg::LATCH_NMI:   nmi_next = s_data.write_data[0];
                                adcbd_pkg::LATCH_IRQ: begin
                                    if (s_data.write_data[0] && !irq_prev_reg)
                                        irq_wait_next = 1'b1;
                                    irq_prev_next = s_data.write_data[0];
                                end
                                adcbd_pkg::LATCH_VIDEO: video_next = s_data.write_data[0];
                                default: ;
                            endcase
                        end
                    end
                end
            end
            adcbd_pkg::OP_TICK: begin
                // a prescale of zero trips on every tick, same as one
                if (pre_inc >= prescale_cfg_reg) begin
                    prescale_next = 8'd0;
                    decade_next   = (decade_reg == adcbd_pkg::DECADE_LAST) ?
                                    4'd0 : decade_reg + 4'd1;
                end else begin
                    prescale_next = pre_inc;
                end
            end
            adcbd_pkg::OP_IRQ_ACK: irq_wait_next = 1'b0;
            adcbd_pkg::OP_FRAME:   seen_next     = 1'b0;
            default: ;
        endcase

        res_next.sound_irq_pending  = irq_wait_next;
        res_next.nmi_enabled        = nmi_next;
        res_next.video_enabled      = video_next;
        res_next.scanline_read_seen = seen_next;
        res_next.game_running       = started_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_one_reg      <= adcbd_pkg::CFG_DIP_RESET;
            dip_two_reg      <= adcbd_pkg::CFG_DIP_RESET;
            demo_on_reg      <= 8'h00;
            demo_off_reg     <= 8'h00;
            prescale_cfg_reg <= adcbd_pkg::CFG_PRESCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                adcbd_pkg::CFG_DIP_ONE:      dip_one_reg      <= cfg_wr_data;
                adcbd_pkg::CFG_DIP_TWO_BASE: dip_two_reg      <= cfg_wr_data;
                adcbd_pkg::CFG_DEMO_ON:      demo_on_reg      <= cfg_wr_data;
                adcbd_pkg::CFG_DEMO_OFF:     demo_off_reg     <= cfg_wr_data;
                adcbd_pkg::CFG_PRESCALE:     prescale_cfg_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) psg_reg[i] <= 8'h00;
        end else if (s_accept && psg_we) begin
            psg_reg[psg_widx] <= s_data.write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psg_addr0_reg   <= '0;
            psg_addr1_reg   <= '0;
            sound_latch_reg <= '0;
            nmi_reg         <= 1'b0;
            video_reg       <= 1'b0;
            irq_prev_reg    <= 1'b0;
            irq_wait_reg    <= 1'b0;
            started_reg     <= 1'b0;
            seen_reg        <= 1'b0;
            prescale_reg    <= '0;
            decade_reg      <= '0;
        end else if (s_accept) begin
            psg_addr0_reg   <= psg_addr0_next;
            psg_addr1_reg   <= psg_addr1_next;
            sound_latch_reg <= sound_latch_next;
            nmi_reg         <= nmi_next;
            video_reg       <= video_next;
            irq_prev_reg    <= irq_prev_next;
            irq_wait_reg    <= irq_wait_next;
            started_reg     <= started_next;
            seen_reg        <= seen_next;
            prescale_reg    <= prescale_next;
            decade_reg      <= decade_next;
        end
    end

    // stage one: decoded word waiting on RAM data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_res_reg <= res_next;
            st1_sel_reg <= rd_sel;
        end
    end

    always_comb begin
        case (st1_sel_reg)
            adcbd_pkg::RAM_COLOUR: ram_q = colour_q_reg;
            adcbd_pkg::RAM_VIDEO:  ram_q = video_q_reg;
            adcbd_pkg::RAM_WORK:   ram_q = work_q_reg;
            adcbd_pkg::RAM_SPR_A:  ram_q = spr_a_q_reg;
            adcbd_pkg::RAM_SPR_B:  ram_q = spr_b_q_reg;
            adcbd_pkg::RAM_SOUND:  ram_q = sound_q_reg;
            default:               ram_q = st1_res_reg.read_data;
        endcase
    end

    always_comb begin
        st1_out           = st1_res_reg;
        st1_out.read_data = ram_q;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= st1_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/adcbd_checker.sv =====
// Port-level checks for arcade_dual_cpu_bus_decoder, bound to the top level.
// Depends on adcbd_pkg for the payload types.
module adcbd_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input adcbd_pkg::out_t  m_data
);

    // a result held back by the sink keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_rom_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.rom_select |-> m_data.rom_address == 15'd0)
        else $error("rom address without rom select");

    a_rom_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rom_select |-> m_data.read_data == 8'd0 && !m_data.audio_write)
        else $error("rom read carries data or audio write");

    a_audio_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.audio_write |->
            m_data.audio_reg_index == 5'd0 && m_data.audio_reg_value == 8'd0)
        else $error("audio fields without audio write");

endmodule

bind arcade_dual_cpu_bus_decoder adcbd_checker u_adcbd_checker (.*);

// ===== tb/tb_arcade_dual_cpu_bus_decoder.sv =====
// Self-checking bench for arcade_dual_cpu_bus_decoder: directed and random bus words on both CPUs,
// checked word by word against a behavioral predictor of the decoder and its state.
// Depends on adcbd_pkg and the decoder RTL only.
module tb_arcade_dual_cpu_bus_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import adcbd_pkg::*;

    localparam int         IDLE_LIMIT    = 500;
    localparam int         PHASES        = 6;
    localparam int         RANDOM_WORDS  = 200;
    localparam int         MAX_PRINTS    = 100;
    localparam int         RAM_SPAN      = 4096;
    localparam logic [2:0] OP_UNUSED_TOP = 3'd7;

    // predictor plus in-order store of expected result words
    class bus_scoreboard;
        logic [7:0] dip_one, dip_two_base, demo_on, demo_off, prescale;
        logic [7:0] ram_mem [int];   // key: ram select * RAM_SPAN + byte index
        int         filled [$];
        logic [7:0] psg_regs [32];
        logic [3:0] psg_addr [2];
        logic [7:0] snd_latch;
        logic       nmi, video, irq_prev, irq_wait, started, scan_seen;
        logic [7:0] pre_count;
        logic [3:0] decade;
        out_t       expected_words [$];
        int         errors;

        function new();
            dip_one = CFG_DIP_RESET;
            dip_two_base = CFG_DIP_RESET;
            demo_on = '0;
            demo_off = '0;
            prescale = CFG_PRESCALE_RESET;
            foreach (psg_regs[i]) psg_regs[i] = '0;
            psg_addr[0] = '0;
            psg_addr[1] = '0;
            snd_latch = '0;
            {nmi, video, irq_prev, irq_wait, started, scan_seen} = '0;
            pre_count = '0;
            decade = '0;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                CFG_DIP_ONE:      dip_one = v;
                CFG_DIP_TWO_BASE: dip_two_base = v;
                CFG_DEMO_ON:      demo_on = v;
                CFG_DEMO_OFF:     demo_off = v;
                CFG_PRESCALE:     prescale = v;
                default: ;
            endcase
        endfunction

        function int ram_key(logic cpu, logic [15:0] a);
            if (cpu) return (a[15:12] == 4'h3) ? int'(RAM_SOUND) * RAM_SPAN + int'(a[9:0]) : -1;
            if (a >= 16'hA000 && a <= 16'hA3FF) return int'(RAM_COLOUR) * RAM_SPAN + int'(a[9:0]);
            if (a >= 16'hA400 && a <= 16'hA7FF) return int'(RAM_VIDEO) * RAM_SPAN + int'(a[9:0]);
            if (a >= 16'hA800 && a <= 16'hAFFF) return int'(RAM_WORK) * RAM_SPAN + int'(a[10:0]);
            if ((a & 16'hFC00) == 16'hB000) return int'(RAM_SPR_A) * RAM_SPAN + int'(a[7:0]);
            if ((a & 16'hFC00) == 16'hB400) return int'(RAM_SPR_B) * RAM_SPAN + int'(a[7:0]);
            return -1;
        endfunction

        function logic [7:0] decade_tone(logic [3:0] d);
            case (d)
                4'd1:    return 8'h10;
                4'd2:    return 8'h20;
                4'd3:    return 8'h30;
                4'd4:    return 8'h40;
                4'd5:    return 8'h90;
                4'd6:    return 8'ha0;
                4'd7:    return 8'hb0;
                4'd8:    return 8'ha0;
                4'd9:    return 8'hd0;
                default: return 8'h00;
            endcase
        endfunction

        function logic [7:0] stored(int k);
            return ram_mem.exists(k) ? ram_mem[k] : 8'h00;
        endfunction

        function logic [7:0] main_byte(in_t w);
            int k;
            k = ram_key(1'b0, w.address);
            if (k >= 0) return stored(k);
            case (w.address)
                ADDR_SCANLINE: begin
                    scan_seen = 1'b1;
                    return w.scanline_count;
                end
                ADDR_DIP_TWO: return dip_two_base | (w.demo_sound_off ? demo_off : demo_on);
                // inputs are active low
                ADDR_IN_ZERO: return {4'hF, ~w.buttons[1], 2'b11, ~w.buttons[0]};
                ADDR_IN_ONE:  return {3'b111, ~w.buttons[6:2]};
                ADDR_IN_TWO:  return 8'hFF;
                ADDR_DIP_ONE: return dip_one;
                default:      return 8'h00;
            endcase
        endfunction

        function logic [7:0] sound_byte(logic [15:0] a);
            if (a < SND_GAP_TOP) return 8'hFF;
            case (a[15:12])
                4'h3: return stored(ram_key(1'b1, a));
                4'h4: begin
                    // chip one ports: A reads the sound latch, B the decade timer
                    if (psg_addr[0] == PSG_PORT_A) return snd_latch;
                    if (psg_addr[0] == PSG_PORT_B) return decade_tone(decade);
                    return psg_regs[{1'b0, psg_addr[0]}];
                end
                4'h6:    return psg_regs[{1'b1, psg_addr[1]}];
                default: return 8'hFF;
            endcase
        endfunction

        function void note_access(in_t w);
            out_t       r;
            int         k;
            logic       chip;
            logic [3:0] sel;
            r = '0;
            case (w.op)
                OP_READ: begin
                    if ((!w.cpu_select && w.address < MAIN_ROM_TOP) ||
                        (w.cpu_select && w.address < SND_ROM_TOP)) begin
                        r.rom_select = 1'b1;
                        r.rom_address = w.address[14:0];
                    end else begin
                        r.read_data = w.cpu_select ? sound_byte(w.address) : main_byte(w);
                    end
                end
                OP_WRITE: begin
                    k = ram_key(w.cpu_select, w.address);
                    if (k >= 0) begin
                        if (!ram_mem.exists(k)) filled.push_back(k);
                        ram_mem[k] = w.write_data;
                        if (k / RAM_SPAN == int'(RAM_VIDEO)) started = 1'b1;
                    end else if (w.cpu_select) begin
                        case (w.address[15:12])
                            4'h4, 4'h6: begin
                                chip = (w.address[15:12] == 4'h6);
                                sel = psg_addr[chip];
                                psg_regs[{chip, sel}] = w.write_data;
                                if (sel < PSG_PORT_A) begin
                                    r.audio_write = 1'b1;
                                    r.audio_reg_index = {chip, sel};
                                    r.audio_reg_value = w.write_data;
                                end
                            end
                            4'h5:    psg_addr[0] = w.write_data[3:0];
                            4'h7:    psg_addr[1] = w.write_data[3:0];
                            default: ;
                        endcase
                    end else if (w.address == ADDR_SCANLINE) begin
                        snd_latch = w.write_data;
                    end else if (w.address[15:4] == LATCH_PAGE) begin
                        case (w.address[3:1])
                            LATCH_NMI: nmi = w.write_data[0];
                            LATCH_IRQ: begin
                                if (w.write_data[0] && !irq_prev) irq_wait = 1'b1;
                                irq_prev = w.write_data[0];
                            end
                            LATCH_VIDEO: video = w.write_data[0];
                            default: ;
                        endcase
                    end
                end
                OP_TICK: begin
                    pre_count = pre_count + 8'd1;
                    if (pre_count >= prescale) begin
                        pre_count = '0;
                        decade = (decade == DECADE_LAST) ? 4'd0 : decade + 4'd1;
                    end
                end
                OP_IRQ_ACK: irq_wait = 1'b0;
                OP_FRAME:   scan_seen = 1'b0;
                default: ;
            endcase
            r.sound_irq_pending = irq_wait;
            r.nmi_enabled = nmi;
            r.video_enabled = video;
            r.scanline_read_seen = scan_seen;
            r.game_running = started;
            expected_words.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, what);
        endtask

        task compare(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(out_t got);
            out_t want;
            if (expected_words.size() == 0) begin
                report("result word with nothing outstanding");
                return;
            end
            want = expected_words.pop_front();
            compare("read_data", 16'(got.read_data), 16'(want.read_data));
            compare("rom_select", 16'(got.rom_select), 16'(want.rom_select));
            compare("rom_address", 16'(got.rom_address), 16'(want.rom_address));
            compare("audio_write", 16'(got.audio_write), 16'(want.audio_write));
            compare("audio_reg_index", 16'(got.audio_reg_index),
                    16'(want.audio_reg_index));
            compare("audio_reg_value", 16'(got.audio_reg_value),
                    16'(want.audio_reg_value));
            compare("sound_irq_pending", 16'(got.sound_irq_pending),
                    16'(want.sound_irq_pending));
            compare("nmi_enabled", 16'(got.nmi_enabled), 16'(want.nmi_enabled));
            compare("video_enabled", 16'(got.video_enabled), 16'(want.video_enabled));
            compare("scanline_read_seen", 16'(got.scanline_read_seen),
                    16'(want.scanline_read_seen));
            compare("game_running", 16'(got.game_running), 16'(want.game_running));
        endtask
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_wr_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_t        s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_t       m_data;

    bus_scoreboard sb;
    int            gap_max_s = 18;
    int            gap_max_m = 18;
    int            idle_cycles = 0;

    arcade_dual_cpu_bus_decoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic in_t mk(logic [2:0] op, logic cpu, logic [15:0] a, logic [7:0] d);
        in_t w;
        w = '0;
        w.op = op;
        w.cpu_select = cpu;
        w.address = a;
        w.write_data = d;
        return w;
    endfunction

    // bus address of a RAM byte already written, with a random mirror where one exists
    function automatic logic [16:0] address_of(int k);
        logic [15:0] idx, mirror;
        idx = 16'(k % RAM_SPAN);
        mirror = 16'($urandom_range(0, 3));
        case (k / RAM_SPAN)
            int'(RAM_COLOUR): return {1'b0, 16'hA000 | idx};
            int'(RAM_VIDEO):  return {1'b0, 16'hA400 | idx};
            int'(RAM_WORK):   return {1'b0, 16'hA800 | idx};
            int'(RAM_SPR_A):  return {1'b0, 16'hB000 | (mirror << 8) | idx};
            int'(RAM_SPR_B):  return {1'b0, 16'hB400 | (mirror << 8) | idx};
            default:          return {1'b1, 16'h3000 | (mirror << 10) | idx};
        endcase
    endfunction

    function automatic logic [15:0] main_target();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 16'h5FFF));
            1: return 16'hA000 + 16'($urandom_range(0, 16'h0FFF));
            2: return 16'hB000 + 16'($urandom_range(0, 16'h07FF));
            3: return ADDR_SCANLINE;
            4: return ADDR_DIP_TWO;
            5, 6: return ADDR_IN_ZERO + 16'($urandom_range(0, 15));
            7: begin
                case ($urandom_range(0, 3))
                    0:       return ADDR_IN_ZERO;
                    1:       return ADDR_IN_ONE;
                    2:       return ADDR_IN_TWO;
                    default: return ADDR_DIP_ONE;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] sound_target();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 16'h0FFF));
            1:       return 16'($urandom_range(16'h1000, 16'h2FFF));
            2:       return 16'h3000 + 16'($urandom_range(0, 16'h0FFF));
            3:       return 16'h4000 + 16'($urandom_range(0, 16'h0FFF));
            4:       return 16'h5000 + 16'($urandom_range(0, 16'h0FFF));
            5:       return 16'h6000 + 16'($urandom_range(0, 16'h0FFF));
            6:       return 16'h7000 + 16'($urandom_range(0, 16'h0FFF));
            7:       return 16'($urandom_range(16'h8000, 16'hFFFF));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t next_access();
        in_t w;
        int  pick, k;
        w.cpu_select = 1'($urandom_range(0, 1));
        w.address = 16'($urandom);
        w.write_data = 8'($urandom);
        w.scanline_count = 8'($urandom);
        w.buttons = 7'($urandom);
        w.demo_sound_off = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 9) begin
            w.op = OP_TICK;
        end else if (pick < 12) begin
            w.op = OP_IRQ_ACK;
        end else if (pick < 15) begin
            w.op = OP_FRAME;
        end else if (pick < 17) begin
            w.op = 3'($urandom_range(int'(OP_FRAME) + 1, int'(OP_UNUSED_TOP)));
        end else if (pick < 37 && sb.filled.size() > 0) begin
            w.op = OP_READ;
            k = sb.filled[$urandom_range(0, sb.filled.size() - 1)];
            {w.cpu_select, w.address} = address_of(k);
        end else begin
            w.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            w.address = w.cpu_select ? sound_target() : main_target();
        end
        // a never-written RAM byte gets written instead of read
        k = sb.ram_key(w.cpu_select, w.address);
        if (w.op == OP_READ && k >= 0 && !sb.ram_mem.exists(k)) w.op = OP_WRITE;
        return w;
    endfunction

    task automatic send_word(input in_t w);
        int gap;
        gap = $urandom_range(0, gap_max_s);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(w);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_phase(int ph);
        case (ph)
            1: begin
                write_reg(CFG_DIP_ONE, 8'h00);
                write_reg(CFG_DIP_TWO_BASE, 8'h00);
                write_reg(CFG_DEMO_ON, 8'hFF);
                write_reg(CFG_DEMO_OFF, 8'h00);
                write_reg(CFG_PRESCALE, 8'd1);
            end
            2: begin
                write_reg(CFG_DIP_ONE, 8'hFF);
                write_reg(CFG_DIP_TWO_BASE, 8'h00);
                write_reg(CFG_DEMO_ON, 8'h00);
                write_reg(CFG_DEMO_OFF, 8'hFF);
                write_reg(CFG_PRESCALE, 8'd255);
            end
            default: begin
                write_reg(CFG_DIP_ONE, 8'($urandom));
                write_reg(CFG_DIP_TWO_BASE, 8'($urandom));
                write_reg(CFG_DEMO_ON, 8'($urandom));
                write_reg(CFG_DEMO_OFF, 8'($urandom));
                // half the time a short prescale, so the decade counter steps often within a phase
                write_reg(CFG_PRESCALE, 8'($urandom_range(0, 1) ? $urandom_range(1, 6)
                                                               : $urandom_range(1, 255)));
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stall before each word
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, gap_max_m);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_t plan [$];
        in_t w;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words, run with the reset register values
        plan.push_back(mk(OP_READ, 1'b0, 16'h0000, 8'h00));
        plan.push_back(mk(OP_READ, 1'b0, 16'h5FFF, 8'h00));
        plan.push_back(mk(OP_READ, 1'b1, 16'h0FFF, 8'h00));
        plan.push_back(mk(OP_READ, 1'b1, 16'h1000, 8'h00));
        plan.push_back(mk(OP_READ, 1'b1, 16'hFFFF, 8'h00));
        plan.push_back(mk(OP_READ, 1'b0, 16'hFFFF, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hA7FF, 8'hFF));
        plan.push_back(mk(OP_READ, 1'b0, 16'hA7FF, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b0, ADDR_SCANLINE, 8'hA5));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h5000, 8'h0E));
        plan.push_back(mk(OP_READ, 1'b1, 16'h4000, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h5FFF, 8'hFF));
        plan.push_back(mk(OP_READ, 1'b1, 16'h4FFF, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h4000, 8'h77));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h7000, 8'h0D));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h6000, 8'hFF));
        plan.push_back(mk(OP_READ, 1'b1, 16'h6FFF, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hC304, 8'h01));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hC305, 8'hFF));
        plan.push_back(mk(OP_IRQ_ACK, 1'b0, 16'h0000, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hC300, 8'h01));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hC309, 8'h01));
        plan.push_back(mk(OP_WRITE, 1'b0, 16'hC302, 8'h01));
        w = mk(OP_READ, 1'b0, ADDR_SCANLINE, 8'h00);
        w.scanline_count = 8'hFF;
        plan.push_back(w);
        plan.push_back(mk(OP_FRAME, 1'b0, 16'h0000, 8'h00));
        plan.push_back(mk(OP_TICK, 1'b1, 16'h0000, 8'h00));
        plan.push_back(mk(OP_UNUSED_TOP, 1'b1, 16'hFFFF, 8'hFF));
        w = mk(OP_READ, 1'b0, ADDR_IN_ZERO, 8'h00);
        w.buttons = 7'h7F;
        plan.push_back(w);
        w = mk(OP_READ, 1'b0, ADDR_IN_ONE, 8'h00);
        w.buttons = 7'h7F;
        plan.push_back(w);
        w = mk(OP_READ, 1'b0, ADDR_DIP_TWO, 8'h00);
        w.demo_sound_off = 1'b1;
        plan.push_back(w);
        plan.push_back(mk(OP_READ, 1'b0, ADDR_DIP_ONE, 8'h00));
        plan.push_back(mk(OP_WRITE, 1'b1, 16'h8000, 8'h5A));

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_max_s = (ph % 3 == 1) ? 0 : 18;
            gap_max_m = (ph % 2 == 1) ? 0 : 18;
            if (ph > 0) begin
                settle();
                program_phase(ph);
            end else begin
                foreach (plan[i]) send_word(plan[i]);
            end
            repeat (RANDOM_WORDS) send_word(next_access());
        end
        settle();
        repeat (4) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/adcbd_pkg.sv
rtl/arcade_dual_cpu_bus_decoder.sv
rtl/adcbd_checker.sv
tb/tb_arcade_dual_cpu_bus_decoder.sv
